// ===== hdl/tcs_pkg.sv =====
package tcs_pkg;

  // Operation codes carried on the opcode field.
  localparam logic [2:0] OPC_PUT   = 3'd0;
  localparam logic [2:0] OPC_UP    = 3'd1;
  localparam logic [2:0] OPC_DOWN  = 3'd2;
  localparam logic [2:0] OPC_CLEAR = 3'd3;
  localparam logic [2:0] OPC_READ  = 3'd4;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7F;

  localparam logic [15:0] BLANK_CELL = 16'h0020;
  localparam int TAB_STEP = 4;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_PUT, ST_SCROLL, ST_LASTBLANK, ST_UP, ST_SCAN, ST_CMP,
    ST_APPEND, ST_UPTAIL, ST_DOWN, ST_COPY, ST_CLEAR, ST_RD, ST_RD2
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_PUT, OP_UP_SAVE, OP_UP_STEP, OP_DOWN_STEP,
    OP_RD_ISSUE, OP_RD_CAPTURE, OP_VIEW_SYNC, OP_CLR_REGS
  } dp_op_t;

  typedef enum logic [2:0] {
    SW_NONE, SW_BLANK, SW_SCROLL, SW_LASTBLANK, SW_SCAN, SW_CMP, SW_APPEND, SW_COPY
  } sweep_t;

  typedef struct packed {
    dp_op_t op;
    sweep_t sweep;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic need_scroll;
    logic hist_gt_rows;
    logic hist_nonzero;
    logic viewing;
    logic cmp_eq;
  } dp_status_t;

endpackage

// ===== hdl/text_console_with_scrollback_unit.sv =====
// Text console with scrollback. A command is taken when start is high and busy is low;
// exactly one result follows, shown for a single cycle with out_valid high, and the
// receiver cannot stall it, so it must capture every result beat. The screen is a
// ROWS*COLUMNS cell memory and history a HISTORY_ROWS*COLUMNS memory, each with one
// write and one registered read port, and every multi-cell action walks the screen one
// cell per clock. A put that scrolls also moves every row up one and blanks the last row.
// Clear and each scroll-view redraw sweep the whole screen; entering history view adds
// a scan of the screen, a compare of one row and an append of up to ROWS*COLUMNS cells.
// After reset the block blanks the screen with busy high. The text color register may be
// written at any time through its valid/ready port, but is meant to change only while idle.
module text_console_with_scrollback_unit #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int HISTORY_ROWS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic        out_cursor_on,
  output logic        out_scrolled_back,
  output logic [8:0]  out_view_top,
  output logic [8:0]  out_history_count,
  output logic [15:0] out_cell_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_text_color
);

  tcs_pkg::dp_cmd_t    cmd;
  tcs_pkg::dp_status_t st;

  // The color register is always ready to take a beat.
  assign cfg_ready = 1'b1;

  // The controller sequences each command through sweeps of the datapath.
  tcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .opcode    (in_opcode),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The datapath holds the memories, the cursor and view state and the sweep engine.
  tcs_dp #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .HISTORY_ROWS (HISTORY_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_text_color),
    .char_code     (in_char_code),
    .cell_index    (in_cell_index),
    .cursor_col    (out_cursor_col),
    .cursor_row    (out_cursor_row),
    .cursor_on     (out_cursor_on),
    .scrolled_back (out_scrolled_back),
    .view_top      (out_view_top),
    .history_count (out_history_count),
    .cell_data     (out_cell_data)
  );

  // A result is only shown once the controller has returned to idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // An accepted command either starts work or answers in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command lost");

  // The reported cursor row always lies on the screen.
  a_row_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_row) < 32'(ROWS)))
    else $error("cursor row off screen");

  // The screen is never written by a sweep while the block is idle.
  a_idle_no_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (cmd.sweep == tcs_pkg::SW_NONE))
    else $error("sweep active while idle");

endmodule

// ===== hdl/tcs_ctrl.sv =====
module tcs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          opcode,
  input  tcs_pkg::dp_status_t st,
  output tcs_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                out_valid
);

  tcs_pkg::ctrl_state_t state_r, state_nxt;
  logic finish;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcs_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcs_pkg::ST_INIT: begin
        if (st.sweep_done) state_nxt = tcs_pkg::ST_IDLE;
      end
      tcs_pkg::ST_IDLE: begin
        if (start) begin
          case (opcode)
            tcs_pkg::OPC_PUT:   state_nxt = tcs_pkg::ST_PUT;
            tcs_pkg::OPC_UP:    state_nxt = tcs_pkg::ST_UP;
            tcs_pkg::OPC_DOWN:  state_nxt = tcs_pkg::ST_DOWN;
            tcs_pkg::OPC_CLEAR: state_nxt = tcs_pkg::ST_CLEAR;
            tcs_pkg::OPC_READ:  state_nxt = tcs_pkg::ST_RD;
            default:            state_nxt = tcs_pkg::ST_IDLE;
          endcase
        end
      end
      tcs_pkg::ST_PUT: begin
        state_nxt = st.need_scroll ? tcs_pkg::ST_SCROLL : tcs_pkg::ST_IDLE;
      end
      tcs_pkg::ST_SCROLL: begin
        if (st.sweep_done) state_nxt = tcs_pkg::ST_LASTBLANK;
      end
      tcs_pkg::ST_LASTBLANK, tcs_pkg::ST_COPY, tcs_pkg::ST_CLEAR: begin
        if (st.sweep_done) state_nxt = tcs_pkg::ST_IDLE;
      end
      tcs_pkg::ST_UP: begin
        if (!st.viewing) state_nxt = tcs_pkg::ST_SCAN;
        else state_nxt = st.hist_gt_rows ? tcs_pkg::ST_COPY : tcs_pkg::ST_IDLE;
      end
      tcs_pkg::ST_SCAN: begin
        if (st.sweep_done)
          state_nxt = st.hist_nonzero ? tcs_pkg::ST_CMP : tcs_pkg::ST_APPEND;
      end
      tcs_pkg::ST_CMP: begin
        if (st.sweep_done)
          state_nxt = st.cmp_eq ? tcs_pkg::ST_UPTAIL : tcs_pkg::ST_APPEND;
      end
      tcs_pkg::ST_APPEND: begin
        if (st.sweep_done) state_nxt = tcs_pkg::ST_UPTAIL;
      end
      tcs_pkg::ST_UPTAIL: begin
        state_nxt = st.hist_gt_rows ? tcs_pkg::ST_COPY : tcs_pkg::ST_IDLE;
      end
      tcs_pkg::ST_DOWN: state_nxt = tcs_pkg::ST_COPY;
      tcs_pkg::ST_RD:   state_nxt = tcs_pkg::ST_RD2;
      tcs_pkg::ST_RD2:  state_nxt = tcs_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd.op    = tcs_pkg::OP_NONE;
    cmd.sweep = tcs_pkg::SW_NONE;
    finish    = 1'b0;
    unique case (state_r)
      tcs_pkg::ST_INIT: cmd.sweep = tcs_pkg::SW_BLANK;
      tcs_pkg::ST_IDLE: begin
        if (start) begin
          cmd.op = tcs_pkg::OP_LATCH;
          finish = (opcode != tcs_pkg::OPC_PUT) && (opcode != tcs_pkg::OPC_UP) &&
                   (opcode != tcs_pkg::OPC_DOWN) && (opcode != tcs_pkg::OPC_CLEAR) &&
                   (opcode != tcs_pkg::OPC_READ);
        end
      end
      tcs_pkg::ST_PUT: begin
        cmd.op = tcs_pkg::OP_PUT;
        finish = !st.need_scroll;
      end
      tcs_pkg::ST_SCROLL: cmd.sweep = tcs_pkg::SW_SCROLL;
      tcs_pkg::ST_LASTBLANK: begin
        cmd.sweep = tcs_pkg::SW_LASTBLANK;
        cmd.op    = tcs_pkg::OP_VIEW_SYNC;
        finish    = st.sweep_done;
      end
      tcs_pkg::ST_UP: begin
        if (!st.viewing) begin
          cmd.op = tcs_pkg::OP_UP_SAVE;
        end else begin
          cmd.op = tcs_pkg::OP_UP_STEP;
          finish = !st.hist_gt_rows;
        end
      end
      tcs_pkg::ST_SCAN:   cmd.sweep = tcs_pkg::SW_SCAN;
      tcs_pkg::ST_CMP:    cmd.sweep = tcs_pkg::SW_CMP;
      tcs_pkg::ST_APPEND: cmd.sweep = tcs_pkg::SW_APPEND;
      tcs_pkg::ST_UPTAIL: begin
        cmd.op = tcs_pkg::OP_UP_STEP;
        finish = !st.hist_gt_rows;
      end
      tcs_pkg::ST_DOWN: cmd.op = tcs_pkg::OP_DOWN_STEP;
      tcs_pkg::ST_COPY: begin
        cmd.sweep = tcs_pkg::SW_COPY;
        finish    = st.sweep_done;
      end
      tcs_pkg::ST_CLEAR: begin
        cmd.sweep = tcs_pkg::SW_BLANK;
        cmd.op    = tcs_pkg::OP_CLR_REGS;
        finish    = st.sweep_done;
      end
      tcs_pkg::ST_RD: cmd.op = tcs_pkg::OP_RD_ISSUE;
      tcs_pkg::ST_RD2: begin
        cmd.op = tcs_pkg::OP_RD_CAPTURE;
        finish = 1'b1;
      end
    endcase
  end

  assign busy      = (state_r != tcs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/tcs_dp.sv =====
module tcs_dp #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int HISTORY_ROWS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcs_pkg::dp_cmd_t    cmd,
  output tcs_pkg::dp_status_t st,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic [7:0]          char_code,
  input  logic [10:0]         cell_index,
  output logic [6:0]          cursor_col,
  output logic [4:0]          cursor_row,
  output logic                cursor_on,
  output logic                scrolled_back,
  output logic [8:0]          view_top,
  output logic [8:0]          history_count,
  output logic [15:0]         cell_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int PXW   = AW + 1;
  localparam int HD    = HISTORY_ROWS * COLUMNS;
  localparam int HAW   = $clog2(HD);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int CW1   = CLW + 1;
  localparam int RWW   = $clog2(ROWS);
  localparam int HRW   = $clog2(HISTORY_ROWS + 1);
  localparam int HXW   = HRW + CLW + 2;

  function automatic logic [AW-1:0] scr_addr(input logic [RWW-1:0] r,
                                             input logic [CLW-1:0] c);
    logic [PXW-1:0] t;
    t = PXW'(r) * PXW'(COLUMNS) + PXW'(c);
    return t[AW-1:0];
  endfunction

  function automatic logic [HAW-1:0] hist_addr(input logic [HRW:0] r,
                                               input logic [CLW-1:0] c);
    logic [HXW-1:0] t;
    t = HXW'(r) * HXW'(COLUMNS) + HXW'(c);
    return t[HAW-1:0];
  endfunction

  // Screen and scrollback memories.
  logic [15:0] scr_mem [CELLS];
  logic [15:0] hist_mem [HD];
  logic            scr_we, hist_we;
  logic [AW-1:0]   scr_waddr, scr_raddr;
  logic [HAW-1:0]  hist_waddr, hist_raddr;
  logic [15:0]     scr_wdata, hist_wdata, scr_rdata_r, hist_rdata_r;

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
    scr_rdata_r <= scr_mem[scr_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rdata_r <= hist_mem[hist_raddr];
  end

  // Architectural state.
  logic [7:0]     text_color_r;
  logic [7:0]     ch_r;
  logic [10:0]    idx_r;
  logic [CLW-1:0] cur_col_r, cur_col_nxt, saved_col_r, saved_col_nxt;
  logic [RWW-1:0] cur_row_r, cur_row_nxt, saved_row_r, saved_row_nxt;
  logic [RWW-1:0] last_r, last_nxt;
  logic [HRW-1:0] hist_rows_r, hist_rows_nxt, view_row_r, view_row_nxt;
  logic [HRW-1:0] copy_first_r, copy_first_nxt;
  logic           viewing_r, viewing_nxt, cursor_shown_r, cursor_shown_nxt;
  logic [15:0]    cell_data_r, cell_data_nxt;

  // Sweep engine: an issue stage that reads, a process stage that writes, scans or compares.
  logic [CLW-1:0] col_r, p_col_r;
  logic [RWW-1:0] row_r, p_row_r;
  logic [AW-1:0]  cnt_r, p_cnt_r;
  logic           iss_end_r, p_v_r, p_last_r, eq_r;
  logic           sweeping, iss, last_issue, done, mismatch;
  logic [RWW-1:0] lr;

  always_comb begin
    unique case (cmd.sweep)
      tcs_pkg::SW_LASTBLANK, tcs_pkg::SW_CMP: lr = '0;
      tcs_pkg::SW_APPEND:                     lr = last_r;
      default:                                lr = RWW'(ROWS - 1);
    endcase
  end

  assign sweeping   = (cmd.sweep != tcs_pkg::SW_NONE);
  assign iss        = sweeping && !iss_end_r;
  assign last_issue = (col_r == CLW'(COLUMNS - 1)) && (row_r == lr);
  assign done       = p_v_r && p_last_r;
  assign mismatch   = (scr_rdata_r != hist_rdata_r);

  always_ff @(posedge clk) begin
    if (!rst_n || !sweeping || done) begin
      col_r     <= '0;
      row_r     <= '0;
      cnt_r     <= '0;
      iss_end_r <= 1'b0;
      p_v_r     <= 1'b0;
      p_last_r  <= 1'b0;
      eq_r      <= 1'b1;
    end else begin
      p_v_r    <= iss;
      p_last_r <= iss && last_issue;
      p_col_r  <= col_r;
      p_row_r  <= row_r;
      p_cnt_r  <= cnt_r;
      if (p_v_r && mismatch) eq_r <= 1'b0;
      if (iss) begin
        if (last_issue) begin
          iss_end_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + AW'(1);
          if (col_r == CLW'(COLUMNS - 1)) begin
            col_r <= '0;
            row_r <= row_r + RWW'(1);
          end else begin
            col_r <= col_r + CLW'(1);
          end
        end
      end
    end
  end

  // Put character: new cursor and the cell it writes.
  logic [CW1-1:0] nc;
  logic [RWW:0]   nr;
  logic           put_we, need_scroll;
  logic [CLW-1:0] wr_col;
  logic [RWW-1:0] wr_row;
  logic [7:0]     put_char;

  always_comb begin
    nc       = CW1'(cur_col_r);
    nr       = (RWW+1)'(cur_row_r);
    put_we   = 1'b0;
    wr_col   = cur_col_r;
    wr_row   = cur_row_r;
    put_char = ch_r;
    if (ch_r == tcs_pkg::CH_LF) begin
      nc = '0;
      nr = nr + (RWW+1)'(1);
    end else if (ch_r == tcs_pkg::CH_TAB) begin
      nc = (nc + CW1'(tcs_pkg::TAB_STEP)) & ~CW1'(tcs_pkg::TAB_STEP - 1);
      if (nc >= CW1'(COLUMNS)) begin
        nc = '0;
        nr = nr + (RWW+1)'(1);
      end
    end else if (ch_r == tcs_pkg::CH_CR) begin
      nc = '0;
    end else if (ch_r == tcs_pkg::CH_BS) begin
      if (cur_col_r != '0) begin
        nc = nc - CW1'(1);
      end else if (cur_row_r != '0) begin
        nr = nr - (RWW+1)'(1);
        nc = CW1'(COLUMNS - 1);
      end
      put_we   = 1'b1;
      wr_col   = nc[CLW-1:0];
      wr_row   = nr[RWW-1:0];
      put_char = tcs_pkg::CH_SPACE;
    end else if (ch_r >= tcs_pkg::CH_SPACE && ch_r <= tcs_pkg::CH_LAST) begin
      put_we = 1'b1;
      nc     = nc + CW1'(1);
    end
    if (nc >= CW1'(COLUMNS)) begin
      nc = '0;
      nr = nr + (RWW+1)'(1);
    end
    need_scroll = (nr >= (RWW+1)'(ROWS));
  end

  logic [HRW-1:0] newest_top, up_base, down_vr;
  logic           append_ok, hist_gt_rows;

  assign hist_gt_rows = (hist_rows_r > HRW'(ROWS));
  assign newest_top   = hist_gt_rows ? hist_rows_r - HRW'(ROWS) : '0;
  assign append_ok    = (hist_rows_r < HRW'(HISTORY_ROWS));
  assign up_base      = viewing_r ? view_row_r : newest_top;
  assign down_vr      = (view_row_r < newest_top) ? view_row_r + HRW'(1) : view_row_r;

  always_comb begin
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    saved_col_nxt    = saved_col_r;
    saved_row_nxt    = saved_row_r;
    last_nxt         = last_r;
    hist_rows_nxt    = hist_rows_r;
    view_row_nxt     = view_row_r;
    copy_first_nxt   = copy_first_r;
    viewing_nxt      = viewing_r;
    cursor_shown_nxt = cursor_shown_r;
    cell_data_nxt    = cell_data_r;
    scr_we           = 1'b0;
    scr_waddr        = p_cnt_r;
    scr_wdata        = tcs_pkg::BLANK_CELL;
    scr_raddr        = cnt_r;
    hist_we          = 1'b0;
    hist_waddr       = hist_addr((HRW+1)'(hist_rows_r), p_col_r);
    hist_wdata       = scr_rdata_r;
    hist_raddr       = hist_addr((HRW+1)'(copy_first_r) + (HRW+1)'(row_r), col_r);

    unique case (cmd.op)
      tcs_pkg::OP_NONE: ;
      tcs_pkg::OP_LATCH: cell_data_nxt = '0;
      tcs_pkg::OP_PUT: begin
        cur_col_nxt = nc[CLW-1:0];
        cur_row_nxt = need_scroll ? RWW'(ROWS - 1) : nr[RWW-1:0];
        scr_we      = put_we;
        scr_waddr   = scr_addr(wr_row, wr_col);
        scr_wdata   = {text_color_r, put_char};
        if (!viewing_r) view_row_nxt = newest_top;
      end
      tcs_pkg::OP_UP_SAVE: begin
        saved_col_nxt = cur_col_r;
        saved_row_nxt = cur_row_r;
        last_nxt      = '0;
      end
      tcs_pkg::OP_UP_STEP: begin
        viewing_nxt  = 1'b1;
        view_row_nxt = up_base;
        if (hist_gt_rows) begin
          if (up_base != '0) view_row_nxt = up_base - HRW'(1);
          copy_first_nxt   = view_row_nxt;
          cursor_shown_nxt = 1'b0;
        end
      end
      tcs_pkg::OP_DOWN_STEP: begin
        view_row_nxt = down_vr;
        if (down_vr >= newest_top) begin
          viewing_nxt      = 1'b0;
          cursor_shown_nxt = 1'b1;
          cur_col_nxt      = saved_col_r;
          cur_row_nxt      = saved_row_r;
          copy_first_nxt   = newest_top;
        end else begin
          cursor_shown_nxt = 1'b0;
          copy_first_nxt   = down_vr;
        end
      end
      tcs_pkg::OP_RD_ISSUE: scr_raddr = AW'(idx_r);
      tcs_pkg::OP_RD_CAPTURE: begin
        cell_data_nxt = (32'(idx_r) < 32'(CELLS)) ? scr_rdata_r : '0;
      end
      tcs_pkg::OP_VIEW_SYNC: begin
        if (!viewing_r) view_row_nxt = newest_top;
      end
      tcs_pkg::OP_CLR_REGS: begin
        hist_rows_nxt = '0;
        view_row_nxt  = '0;
        viewing_nxt   = 1'b0;
        saved_col_nxt = '0;
        saved_row_nxt = '0;
        cur_col_nxt   = '0;
        cur_row_nxt   = '0;
      end
    endcase

    unique case (cmd.sweep)
      tcs_pkg::SW_NONE: ;
      tcs_pkg::SW_BLANK: scr_we = p_v_r;
      tcs_pkg::SW_SCROLL: begin
        // Row 0 goes to history while live and history is not full; every other row moves up one.
        scr_we    = p_v_r && (p_row_r != '0);
        scr_waddr = p_cnt_r - AW'(COLUMNS);
        scr_wdata = scr_rdata_r;
        hist_we   = p_v_r && (p_row_r == '0) && !viewing_r && append_ok;
        if (done && !viewing_r && append_ok) hist_rows_nxt = hist_rows_r + HRW'(1);
      end
      tcs_pkg::SW_LASTBLANK: begin
        scr_we    = p_v_r;
        scr_waddr = scr_addr(RWW'(ROWS - 1), p_col_r);
      end
      tcs_pkg::SW_SCAN: begin
        if (p_v_r && (scr_rdata_r[7:0] != tcs_pkg::CH_SPACE)) last_nxt = p_row_r;
      end
      tcs_pkg::SW_CMP: begin
        scr_raddr  = scr_addr(last_r, col_r);
        hist_raddr = hist_addr((HRW+1)'(hist_rows_r) - (HRW+1)'(1), col_r);
      end
      tcs_pkg::SW_APPEND: begin
        hist_we = p_v_r && append_ok;
        if (p_v_r && append_ok && (p_col_r == CLW'(COLUMNS - 1)))
          hist_rows_nxt = hist_rows_r + HRW'(1);
      end
      tcs_pkg::SW_COPY: begin
        scr_we = p_v_r;
        if ((HRW+1)'(copy_first_r) + (HRW+1)'(p_row_r) < (HRW+1)'(hist_rows_r))
          scr_wdata = hist_rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r   <= 8'd7;
      cur_col_r      <= '0;
      cur_row_r      <= '0;
      saved_col_r    <= '0;
      saved_row_r    <= '0;
      last_r         <= '0;
      hist_rows_r    <= '0;
      view_row_r     <= '0;
      copy_first_r   <= '0;
      viewing_r      <= 1'b0;
      cursor_shown_r <= 1'b1;
      cell_data_r    <= '0;
    end else begin
      if (cfg_we) text_color_r <= cfg_data;
      cur_col_r      <= cur_col_nxt;
      cur_row_r      <= cur_row_nxt;
      saved_col_r    <= saved_col_nxt;
      saved_row_r    <= saved_row_nxt;
      last_r         <= last_nxt;
      hist_rows_r    <= hist_rows_nxt;
      view_row_r     <= view_row_nxt;
      copy_first_r   <= copy_first_nxt;
      viewing_r      <= viewing_nxt;
      cursor_shown_r <= cursor_shown_nxt;
      cell_data_r    <= cell_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tcs_pkg::OP_LATCH) begin
      ch_r  <= char_code;
      idx_r <= cell_index;
    end
  end

  assign st.sweep_done   = done;
  assign st.need_scroll  = need_scroll;
  assign st.hist_gt_rows = hist_gt_rows;
  assign st.hist_nonzero = (hist_rows_r != '0);
  assign st.viewing      = viewing_r;
  assign st.cmp_eq       = eq_r && !(p_v_r && mismatch);

  assign cursor_col    = 7'(cur_col_r);
  assign cursor_row    = 5'(cur_row_r);
  assign cursor_on     = cursor_shown_r;
  assign scrolled_back = viewing_r;
  assign view_top      = 9'(view_row_r);
  assign history_count = 9'(hist_rows_r);
  assign cell_data     = cell_data_r;

endmodule
